// ===== sv/pcsb_pkg.sv =====
package pcsb_pkg;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_ITER,
    ST_CHK,
    ST_EVAL,
    ST_BDIV,
    ST_RD,
    ST_UPD,
    ST_DONE
  } state_t;

  // Opcodes
  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  // Unused code: no state change, read/clear style result
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Result status codes
  localparam logic [2:0] STS_UPDATED  = 3'd0;
  localparam logic [2:0] STS_NOTNEAR  = 3'd1;
  localparam logic [2:0] STS_HEIGHT   = 3'd2;
  localparam logic [2:0] STS_RANGE    = 3'd3;
  localparam logic [2:0] STS_ANGLE    = 3'd4;
  localparam logic [2:0] STS_RDCLR    = 3'd5;

  // Register indexes
  localparam logic [2:0] REG_MIN_HEIGHT = 3'd0;
  localparam logic [2:0] REG_MAX_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RANGE_MIN  = 3'd2;
  localparam logic [2:0] REG_RANGE_MAX  = 3'd3;
  localparam logic [2:0] REG_ANGLE_MIN  = 3'd4;
  localparam logic [2:0] REG_ANGLE_MAX  = 3'd5;
  localparam logic [2:0] REG_ANGLE_STEP = 3'd6;
  localparam logic [2:0] REG_FILL_CODE  = 3'd7;

  // pi in Q.16 and Q3.13
  localparam logic signed [20:0] PI_Q16 = 21'sd205887;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;

  // Last iteration of the CORDIC / divider loops
  localparam logic [4:0] ITER_LAST = 5'd16;
  localparam logic [4:0] SQRT_ITERS = 5'd16;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       mul;
    logic       prep;
    logic       step;
    logic       chk;
    logic       eval;
    logic       bstep;
    logic       rd;
    logic       upd;
    logic       clr;
    logic       out_load;
    logic [4:0] iter;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       reject;
    logic       past;
  } sts_t;

  // round(atan(2^-i) * 65536)
  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd51472;
      5'd1:  v = 17'd30386;
      5'd2:  v = 17'd16055;
      5'd3:  v = 17'd8150;
      5'd4:  v = 17'd4091;
      5'd5:  v = 17'd2047;
      5'd6:  v = 17'd1024;
      5'd7:  v = 17'd512;
      5'd8:  v = 17'd256;
      5'd9:  v = 17'd128;
      5'd10: v = 17'd64;
      5'd11: v = 17'd32;
      5'd12: v = 17'd16;
      5'd13: v = 17'd8;
      5'd14: v = 17'd4;
      5'd15: v = 17'd2;
      5'd16: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/point_cloud_to_scan_binning.sv =====
// Channel   Signals                                         Direction
// input     in_valid, in_ready, opcode, x_mm, y_mm, z_mm,   in
//           bin_select
// result    out_valid, out_ready, status, bin_index,        out
//           range_out, angle_out, bin_count
// config    cfg_we, cfg_index, cfg_data                     in
//
// One transaction at a time. An accumulate runs the 17-step CORDIC/square root/
// divider loop and then, unless rejected, a second 17-step divider run for the
// bin number; a read runs the first loop only, and a clear also sweeps the bins.
// After reset a clearing pass over all NUM_BINS bins runs before in_ready rises.
// A finished result sits in the output register; the next transaction is
// taken meanwhile, and only its result waits for out_ready.
module point_cloud_to_scan_binning #(
  parameter int NUM_BINS = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] x_mm,
  input  logic signed [15:0] y_mm,
  input  logic signed [15:0] z_mm,
  input  logic [8:0]         bin_select,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [8:0]         bin_index,
  output logic [15:0]        range_out,
  output logic signed [15:0] angle_out,
  output logic [9:0]         bin_count,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import pcsb_pkg::*;

  cmd_t                        cmd;
  sts_t                        sts;
  logic [$clog2(NUM_BINS)-1:0] clr_addr;

  pcsb_ctrl #(
    .NUM_BINS (NUM_BINS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .clr_addr  (clr_addr)
  );

  pcsb_dp #(
    .NUM_BINS (NUM_BINS)
  ) u_dp (
    .clk        (clk),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rst        (rst),
    .opcode     (opcode),
    .x_mm       (x_mm),
    .y_mm       (y_mm),
    .z_mm       (z_mm),
    .bin_select (bin_select),
    .cmd        (cmd),
    .clr_addr   (clr_addr),
    .sts        (sts),
    .status     (status),
    .bin_index  (bin_index),
    .range_out  (range_out),
    .angle_out  (angle_out),
    .bin_count  (bin_count)
  );

endmodule

// ===== sv/pcsb_ram.sv =====
module pcsb_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pcsb_ctrl.sv =====
module pcsb_ctrl #(
  parameter int NUM_BINS = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  pcsb_pkg::sts_t              sts,
  output pcsb_pkg::cmd_t              cmd,
  output logic [$clog2(NUM_BINS)-1:0] clr_addr
);
  import pcsb_pkg::*;

  localparam int AW = $clog2(NUM_BINS);

  state_t        state, state_next;
  logic [4:0]    iter, iter_next;
  logic [AW-1:0] cnt, cnt_next;
  logic          boot, boot_next;
  logic          out_valid_next;

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      iter      <= '0;
      cnt       <= '0;
      boot      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      iter      <= iter_next;
      cnt       <= cnt_next;
      boot      <= boot_next;
      out_valid <= out_valid_next;
    end
  end

  assign clr_addr = cnt;

  // Next state and commands
  always_comb begin
    state_next     = state;
    iter_next      = iter;
    cnt_next       = cnt;
    boot_next      = boot;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.iter       = iter;
    case (state)
      ST_CLR: begin
        cmd.clr  = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == AW'(NUM_BINS - 1)) begin
          cnt_next   = '0;
          boot_next  = 1'b0;
          state_next = boot ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        iter_next  = '0;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        cmd.step  = 1'b1;
        iter_next = iter + 1'b1;
        if (iter == ITER_LAST) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.chk = 1'b1;
        case (sts.op)
          OP_ACC:   state_next = ST_EVAL;
          OP_READ:  state_next = ST_RD;
          OP_CLEAR: begin
            cnt_next   = '0;
            state_next = ST_CLR;
          end
          default:  state_next = ST_DONE;
        endcase
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        iter_next  = '0;
        state_next = sts.reject ? ST_DONE : ST_BDIV;
      end
      ST_BDIV: begin
        cmd.bstep = 1'b1;
        iter_next = iter + 1'b1;
        if (iter == ITER_LAST) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = sts.past ? ST_DONE : ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/pcsb_dp.sv =====
module pcsb_dp #(
  parameter int NUM_BINS = 512
) (
  input  logic                        clk,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [15:0]                 cfg_data,
  input  logic                        rst,
  input  logic [1:0]                  opcode,
  input  logic signed [15:0]          x_mm,
  input  logic signed [15:0]          y_mm,
  input  logic signed [15:0]          z_mm,
  input  logic [8:0]                  bin_select,
  input  pcsb_pkg::cmd_t              cmd,
  input  logic [$clog2(NUM_BINS)-1:0] clr_addr,
  output pcsb_pkg::sts_t              sts,
  output logic [2:0]                  status,
  output logic [8:0]                  bin_index,
  output logic [15:0]                 range_out,
  output logic signed [15:0]          angle_out,
  output logic [9:0]                  bin_count
);
  import pcsb_pkg::*;

  localparam int AW = $clog2(NUM_BINS);
  localparam int CW = $clog2(NUM_BINS + 1);

  // Configuration registers
  logic signed [15:0] z_floor, z_ceil, ang_lo, ang_hi;
  logic [15:0]        rng_lo, rng_hi, angle_step, fill_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_floor    <= 16'sd700;
      z_ceil     <= 16'sd1500;
      rng_lo     <= 16'd100;
      rng_hi     <= 16'd4000;
      ang_lo     <= -16'sd12868;
      ang_hi     <= 16'sd12868;
      angle_step <= 16'd71;
      fill_code  <= 16'd65535;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_HEIGHT: z_floor    <= cfg_data;
        REG_MAX_HEIGHT: z_ceil     <= cfg_data;
        REG_RANGE_MIN:  rng_lo     <= cfg_data;
        REG_RANGE_MAX:  rng_hi     <= cfg_data;
        REG_ANGLE_MIN:  ang_lo     <= cfg_data;
        REG_ANGLE_MAX:  ang_hi     <= cfg_data;
        REG_ANGLE_STEP: angle_step <= cfg_data;
        REG_FILL_CODE:  fill_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [15:0] step_eff;
  assign step_eff = (angle_step == 16'd0) ? 16'd1 : angle_step;

  // Transaction registers
  logic [1:0]         op_r;
  logic signed [15:0] x_r, y_r, z_r;
  logic [8:0]         sel_r;
  logic signed [31:0] xx, yy;
  logic [31:0]        sq;
  logic [17:0]        srem;
  logic [15:0]        root;
  logic signed [31:0] cx, cy;
  logic signed [20:0] za;
  logic [16:0]        dq;
  logic [15:0]        dr, dd;
  logic               span_pos;
  logic [CW-1:0]      count_r;
  logic [2:0]         res_status;
  logic [8:0]         res_index;
  logic [15:0]        res_range;
  logic signed [15:0] res_angle;
  logic [AW-1:0]      addr_r;

  // Combinational helpers
  logic signed [16:0] xe, ye, xn, yn;
  logic signed [16:0] span;
  logic signed [31:0] dx, dy;
  logic signed [20:0] at;
  logic [19:0]        sh;
  logic [17:0]        trial;
  logic [16:0]        rs;
  logic               ge;
  logic signed [20:0] zr;
  logic signed [20:0] zs;
  logic signed [15:0] ang;
  logic signed [16:0] diff;
  logic               h_rej, r_rej, a_rej;
  logic [16:0]        rdata;
  logic               hit, sel_ok;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [16:0]        wdata;

  always_comb begin
    xe    = {x_r[15], x_r};
    ye    = {y_r[15], y_r};
    xn    = x_r[15] ? -xe : xe;
    yn    = x_r[15] ? -ye : ye;
    span  = {ang_hi[15], ang_hi} - {ang_lo[15], ang_lo};
    dx    = cx >>> cmd.iter;
    dy    = cy >>> cmd.iter;
    at    = $signed({4'b0, atan_q16(cmd.iter)});
    sh    = {srem, sq[31:30]};
    trial = {root, 2'b01};
    rs    = {dr, dq[16]};
    ge    = (rs >= {1'b0, dd});
    zr    = za + 21'sd4;
    zs    = zr >>> 3;
    if (y_r == 16'sd0) begin
      ang = x_r[15] ? PI_Q13 : 16'sd0;
    end else begin
      ang = zs[15:0];
    end
    diff   = {res_angle[15], res_angle} - {ang_lo[15], ang_lo};
    h_rej  = (z_r < z_floor) || (z_r > z_ceil);
    r_rej  = (res_range < rng_lo) || (res_range > rng_hi);
    a_rej  = (res_angle < ang_lo) || (res_angle > ang_hi);
    hit    = !rdata[16] || (res_range < rdata[15:0]);
    sel_ok = (32'(sel_r) < NUM_BINS);
  end

  assign sts.op     = op_r;
  assign sts.reject = h_rej || r_rej || a_rej;
  assign sts.past   = (op_r == OP_ACC) && (dq >= 17'(count_r));

  // Arithmetic sequencing
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      x_r   <= x_mm;
      y_r   <= y_mm;
      z_r   <= z_mm;
      sel_r <= bin_select;
    end
    if (cmd.mul) begin
      xx       <= x_r * x_r;
      yy       <= y_r * y_r;
      cx       <= {{3{xn[16]}}, xn, 12'd0};
      cy       <= {{3{yn[16]}}, yn, 12'd0};
      za       <= x_r[15] ? (y_r[15] ? -PI_Q16 : PI_Q16) : 21'sd0;
      span_pos <= (span > 17'sd0);
      dq       <= 17'($unsigned(span)) + 17'(step_eff) - 17'd1;
      dr       <= '0;
      dd       <= step_eff;
    end
    if (cmd.prep) begin
      sq   <= $unsigned(xx) + $unsigned(yy);
      srem <= '0;
      root <= '0;
    end
    // CORDIC vectoring, square root digit and divider step
    if (cmd.step) begin
      if (cy > 32'sd0) begin
        cx <= cx + dy;
        cy <= cy - dx;
        za <= za + at;
      end else begin
        cx <= cx - dy;
        cy <= cy + dx;
        za <= za - at;
      end
      if (cmd.iter < SQRT_ITERS) begin
        sq <= {sq[29:0], 2'b00};
        if (sh >= {2'b00, trial}) begin
          srem <= 18'(sh - {2'b00, trial});
          root <= {root[14:0], 1'b1};
        end else begin
          srem <= sh[17:0];
          root <= {root[14:0], 1'b0};
        end
      end
    end
    if (cmd.step || cmd.bstep) begin
      dr <= ge ? 16'(rs - {1'b0, dd}) : rs[15:0];
      dq <= {dq[15:0], ge};
    end
    // Latch count and point results
    if (cmd.chk) begin
      if (!span_pos) begin
        count_r <= '0;
      end else if (dq > 17'(NUM_BINS)) begin
        count_r <= CW'(NUM_BINS);
      end else begin
        count_r <= CW'(dq);
      end
      res_status <= STS_RDCLR;
      res_index  <= (op_r == OP_READ) ? sel_r : 9'd0;
      res_range  <= (op_r == OP_ACC) ? root : 16'd0;
      res_angle  <= (op_r == OP_ACC) ? ang : 16'sd0;
    end
    if (cmd.eval) begin
      if (h_rej) begin
        res_status <= STS_HEIGHT;
      end else if (r_rej) begin
        res_status <= STS_RANGE;
      end else begin
        res_status <= STS_ANGLE;
      end
      dq <= diff[16:0];
      dr <= '0;
      dd <= step_eff;
    end
    if (cmd.rd) begin
      addr_r <= raddr;
      if (op_r == OP_ACC) begin
        res_index <= sts.past ? 9'd0 : 9'(dq);
      end
    end
    if (cmd.upd) begin
      if (op_r == OP_ACC) begin
        res_status <= hit ? STS_UPDATED : STS_NOTNEAR;
      end else begin
        res_range <= (sel_ok && rdata[16]) ? rdata[15:0] : fill_code;
      end
    end
    // Output register
    if (cmd.out_load) begin
      status    <= res_status;
      bin_index <= res_index;
      range_out <= res_range;
      angle_out <= res_angle;
      bin_count <= 10'(count_r);
    end
  end

  // Bin store: valid mark above the range
  assign raddr = (op_r == OP_ACC) ? AW'(dq) : AW'(sel_r);
  assign we    = cmd.clr || (cmd.upd && (op_r == OP_ACC) && hit);
  assign waddr = cmd.clr ? clr_addr : addr_r;
  assign wdata = cmd.clr ? 17'd0 : {1'b1, res_range};

  pcsb_ram #(
    .WIDTH (17),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

// ===== sim/point_cloud_to_scan_binning_tb.sv =====
`timescale 1ns / 1ps

module point_cloud_to_scan_binning_tb;
  import pcsb_pkg::*;

  localparam int NBINS = 512;
  localparam int ATAN_Q16 [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8, 4, 2, 1};

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  bin_index;
    logic [15:0] range_out;
    logic [15:0] angle_out;
    logic [9:0]  bin_count;
  } scan_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         opcode;
  logic signed [15:0] x_mm;
  logic signed [15:0] y_mm;
  logic signed [15:0] z_mm;
  logic [8:0]         bin_select;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         status;
  logic [8:0]         bin_index;
  logic [15:0]        range_out;
  logic signed [15:0] angle_out;
  logic [9:0]         bin_count;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  point_cloud_to_scan_binning #(.NUM_BINS(NBINS)) i_dut (.*);

  // Shadow of the block's registers and bin store
  logic signed [15:0] sh_z_floor, sh_z_ceil, sh_ang_lo, sh_ang_hi;
  logic [15:0]        sh_rng_lo, sh_rng_hi, sh_angle_step, sh_fill_code;
  logic [15:0]        sh_bin_range [NBINS];
  logic               sh_bin_valid [NBINS];

  scan_result_t expected_scans [$];
  int n_errors;
  int n_checked;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;

  // Clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int planar_range(int x, int y);
    longint sq;
    longint r;
    sq = longint'(x) * x + longint'(y) * y;
    r = 0;
    while ((r + 1) * (r + 1) <= sq) r++;
    return int'(r);
  endfunction

  function automatic int planar_bearing(int x, int y);
    longint cx, cy, zq, dx, dy;
    cx = x; cy = y; zq = 0;
    if (y == 0) return (x < 0) ? int'(floor_shr(205887 + 4, 3)) : 0;
    if (cx < 0) begin
      zq = (cy >= 0) ? 205887 : -205887;
      cx = -cx;
      cy = -cy;
    end
    cx = cx * 4096;
    cy = cy * 4096;
    for (int i = 0; i < 17; i++) begin
      dx = floor_shr(cx, i);
      dy = floor_shr(cy, i);
      if (cy > 0) begin
        cx += dy; cy -= dx; zq += ATAN_Q16[i];
      end else begin
        cx -= dy; cy += dx; zq -= ATAN_Q16[i];
      end
    end
    return int'(floor_shr(zq + 4, 3));
  endfunction

  function automatic int scan_bin_count();
    int span, stp, n;
    span = int'(sh_ang_hi) - int'(sh_ang_lo);
    stp = (sh_angle_step == 0) ? 1 : int'(sh_angle_step);
    if (span <= 0) return 0;
    n = (span + stp - 1) / stp;
    return (n > NBINS) ? NBINS : n;
  endfunction

  // Predict one transaction and update the shadow store
  function automatic scan_result_t predict_scan(logic [1:0] op, int x, int y, int z,
                                                int sel);
    scan_result_t r;
    int rng, ang, cnt, stp, b;
    cnt = scan_bin_count();
    r = '0;
    r.status = STS_RDCLR;
    r.bin_count = cnt[9:0];
    if (op == OP_ACC) begin
      rng = planar_range(x, y);
      ang = planar_bearing(x, y);
      r.range_out = rng[15:0];
      r.angle_out = ang[15:0];
      if (z < sh_z_floor || z > sh_z_ceil) r.status = STS_HEIGHT;
      else if (rng < sh_rng_lo || rng > sh_rng_hi) r.status = STS_RANGE;
      else if (ang < sh_ang_lo || ang > sh_ang_hi) r.status = STS_ANGLE;
      else begin
        stp = (sh_angle_step == 0) ? 1 : int'(sh_angle_step);
        b = (ang - int'(sh_ang_lo)) / stp;
        if (b >= cnt) r.status = STS_ANGLE;
        else begin
          r.bin_index = b[8:0];
          if (!sh_bin_valid[b] || rng < sh_bin_range[b]) begin
            sh_bin_valid[b] = 1'b1;
            sh_bin_range[b] = rng[15:0];
            r.status = STS_UPDATED;
          end else r.status = STS_NOTNEAR;
        end
      end
    end else if (op == OP_READ) begin
      r.bin_index = sel[8:0];
      r.range_out = sh_bin_valid[sel] ? sh_bin_range[sel] : sh_fill_code;
    end else if (op == OP_CLEAR) begin
      for (int i = 0; i < NBINS; i++) sh_bin_valid[i] = 1'b0;
    end
    return r;
  endfunction

  // Send one transaction on the input channel
  task automatic send_item(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z, logic [8:0] sel);
    scan_result_t exp_item;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    opcode <= op; x_mm <= x; y_mm <= y; z_mm <= z; bin_select <= sel;
    in_valid <= 1'b1;
    exp_item = predict_scan(op, int'($signed(x)), int'($signed(y)),
                            int'($signed(z)), int'(sel));
    expected_scans = {expected_scans, exp_item};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (expected_scans.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (60) @(negedge clk);
  endtask

  // Register write, to be made only while the block is idle; write_reg itself does not wait for that
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_HEIGHT: sh_z_floor = val;
      REG_MAX_HEIGHT: sh_z_ceil = val;
      REG_RANGE_MIN:  sh_rng_lo = val;
      REG_RANGE_MAX:  sh_rng_hi = val;
      REG_ANGLE_MIN:  sh_ang_lo = val;
      REG_ANGLE_MAX:  sh_ang_hi = val;
      REG_ANGLE_STEP: sh_angle_step = val;
      default:        sh_fill_code = val;
    endcase
    @(negedge clk);
  endtask

  task automatic write_all(logic [15:0] mnh, logic [15:0] mxh, logic [15:0] rmn,
                           logic [15:0] rmx, logic [15:0] amn, logic [15:0] amx,
                           logic [15:0] stp, logic [15:0] fill);
    wait_drained();
    write_reg(REG_MIN_HEIGHT, mnh);
    write_reg(REG_MAX_HEIGHT, mxh);
    write_reg(REG_RANGE_MIN, rmn);
    write_reg(REG_RANGE_MAX, rmx);
    write_reg(REG_ANGLE_MIN, amn);
    write_reg(REG_ANGLE_MAX, amx);
    write_reg(REG_ANGLE_STEP, stp);
    write_reg(REG_FILL_CODE, fill);
  endtask

  // A point mostly inside the current limits, sometimes wild
  task automatic send_random_point();
    int r, a, x, y, z;
    if ($urandom_range(9) < 2) begin
      x = $urandom; y = $urandom; z = $urandom;
    end else begin
      r = $urandom_range(4200, 50);
      a = $urandom_range(359);
      x = $rtoi(r * $cos(a * 3.14159265 / 180.0));
      y = $rtoi(r * $sin(a * 3.14159265 / 180.0));
      z = $urandom_range(1600, 600);
    end
    send_item(OP_ACC, x[15:0], y[15:0], z[15:0], 9'($urandom));
  endtask

  task automatic send_random_mix(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 75) send_random_point();
      else if (k < 95) send_item(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                                 9'($urandom));
      else if (k < 98) send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                                 9'($urandom));
      else send_item(OP_SPARE, 16'($urandom), 16'($urandom), 16'($urandom),
                     9'($urandom));
    end
  endtask

  // Directed points: axis, corner and limit cases under reset settings, then reads, a spare opcode and a clear
  task automatic test_directed();
    send_item(OP_ACC, 16'sd1000, 16'sd0, 16'sd1000, 9'd0);
    send_item(OP_ACC, -16'sd1000, 16'sd0, 16'sd1000, 9'd0);
    send_item(OP_ACC, 16'sd0, 16'sd1000, 16'sd1000, 9'd0);
    send_item(OP_ACC, 16'sd0, -16'sd1000, 16'sd1000, 9'd0);
    send_item(OP_ACC, -16'sd1000, 16'sd5, 16'sd1000, 9'd0);
    send_item(OP_ACC, -16'sd1000, -16'sd5, 16'sd1000, 9'd0);
    send_item(OP_ACC, 16'h8000, 16'h8000, 16'sd700, 9'd0);
    send_item(OP_ACC, 16'h7fff, 16'h7fff, 16'sd1500, 9'd0);
    send_item(OP_ACC, 16'sd1000, 16'sd0, 16'sd699, 9'd0);
    send_item(OP_ACC, 16'sd1000, 16'sd0, 16'sd1501, 9'd0);
    send_item(OP_ACC, 16'sd100, 16'sd0, 16'sd1000, 9'd0);
    send_item(OP_ACC, 16'sd99, 16'sd0, 16'sd1000, 9'd0);
    send_item(OP_ACC, 16'sd4000, 16'sd0, 16'sd1000, 9'd0);
    send_item(OP_ACC, 16'sd4001, 16'sd0, 16'sd1000, 9'd0);
    send_item(OP_ACC, 16'sd900, 16'sd3, 16'sd1000, 9'd0);
    send_item(OP_ACC, 16'sd500, 16'sd2, 16'sd1000, 9'd0);
    send_item(OP_ACC, 16'sd0, 16'sd0, 16'sd1000, 9'd0);
    send_item(OP_READ, 16'h0, 16'h0, 16'h0, 9'd181);
    send_item(OP_READ, 16'hffff, 16'hffff, 16'hffff, 9'd511);
    send_item(OP_READ, 16'h0, 16'h0, 16'h0, 9'd0);
    send_item(OP_SPARE, 16'hffff, 16'hffff, 16'hffff, 9'h1ff);
    send_item(OP_CLEAR, 16'h0, 16'h0, 16'h0, 9'd0);
    send_item(OP_READ, 16'h0, 16'h0, 16'h0, 9'd181);
  endtask

  // Odd settings: inverted heights, zero step, empty span, extremes
  task automatic test_settings();
    write_all(16'sd1500, 16'sd700, 16'd0, 16'd65535, -16'sd25736, 16'sd25736,
              16'd0, 16'd0);
    send_random_mix(30);
    write_all(16'h8000, 16'h7fff, 16'd0, 16'd65535, 16'sd100, 16'sd100, 16'd1, 16'd1234);
    send_random_mix(30);
    write_all(16'h8000, 16'h7fff, 16'd0, 16'd65535, -16'sd25736, 16'sd25736,
              16'd51472, 16'd7);
    send_random_mix(30);
    write_all(16'h8000, 16'h7fff, 16'd0, 16'd65535, -16'sd25736, 16'sd25736,
              16'd0, 16'd65535);
    send_random_mix(60);
    write_all(16'h8000, 16'h7fff, 16'd0, 16'd65535, -16'sd25736, 16'sd25736,
              16'd101, 16'd65535);
    send_random_mix(60);
  endtask

  // Random traffic under the idling phases
  task automatic test_random_phases();
    int pct [4][2];
    pct = '{'{0, 0}, '{57, 0}, '{0, 57}, '{27, 27}};
    for (int p = 0; p < 4; p++) begin
      write_all(16'sd600, 16'sd1550, 16'($urandom_range(150)), 16'($urandom_range(4300, 3000)),
                -16'sd25736 + 16'($urandom_range(3000)), 16'sd25736 - 16'($urandom_range(3000)),
                16'($urandom_range(120, 80)), 16'($urandom));
      send_idle_pct = pct[p][0];
      recv_stall_pct = pct[p][1];
      send_random_mix(200);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off_cycles = 400;
    send_random_mix(40);
  endtask

  // Result checking
  always @(posedge clk) begin
    scan_result_t got, exp_r;
    if (!rst && out_valid && out_ready) begin
      got = '{status, bin_index, range_out, angle_out, bin_count};
      if (expected_scans.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = expected_scans.pop_front();
        n_checked++;
        if (got !== exp_r) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  // Receiver readiness, including the long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #80ms;
    $display("** point_cloud_to_scan_binning: FAILED **");
    $finish;
  end

  initial begin
    rst = 1'b1; in_valid = 1'b0; opcode = OP_ACC; x_mm = '0; y_mm = '0; z_mm = '0;
    bin_select = '0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    n_errors = 0; n_checked = 0; send_idle_pct = 0; recv_stall_pct = 0;
    hold_off_cycles = 0;
    sh_z_floor = 16'sd700; sh_z_ceil = 16'sd1500; sh_rng_lo = 16'd100;
    sh_rng_hi = 16'd4000; sh_ang_lo = -16'sd12868; sh_ang_hi = 16'sd12868;
    sh_angle_step = 16'd71; sh_fill_code = 16'd65535;
    for (int i = 0; i < NBINS; i++) begin
      sh_bin_valid[i] = 1'b0;
      sh_bin_range[i] = '0;
    end
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_settings();
    test_random_phases();
    test_backpressure();
    wait_drained();
    $display("Checked %0d results: directed limits, odd settings, random traffic with",
             n_checked);
    $display("idle and stall phases and a long receiver hold-off; %0d mismatches.",
             n_errors);
    if (n_errors == 0 && expected_scans.size() == 0)
      $display("** point_cloud_to_scan_binning: PASSED **");
    else
      $display("** point_cloud_to_scan_binning: FAILED **");
    $finish;
  end

endmodule
